// ===== rtl/core/rycc_pkg.sv =====
`timescale 1ns / 1ps

package rycc_pkg;

   localparam int PIXEL_W = 8;
   localparam int OPND_W = PIXEL_W + 2;
   localparam int CHANNELS = 3;
   localparam int COEF_FRAC_BITS_DEFAULT = 16;

   typedef enum logic {
      DIR_RGB_TO_YCC = 1'b0,
      DIR_YCC_TO_RGB = 1'b1
   } dir_type;

   typedef struct packed {
      logic valid;
      dir_type dir;
      logic [PIXEL_W-1:0] alpha;
   } beat_ctl_type;

endpackage

// ===== rtl/core/rgb_ycbcr_color_converter_unit.sv =====
`timescale 1ns / 1ps
// A pixel accepted at a clock edge passes the operand, product, sum and clamp registers on its way to the rsp_ ports.
// Throughput: one pixel per cycle; the four register stages are operand setup,
// multiply, sum and clamp. busy is low in every cycle after the first one out of reset.
// The receiver cannot stall, so no result is ever held back.
// Synchronous reset empties the pipeline and sets the direction to RGB to YCbCr.

module rgb_ycbcr_color_converter_unit #(
   parameter int COEF_FRAC_BITS = rycc_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [rycc_pkg::PIXEL_W-1:0] req_first_in,
   input  logic [rycc_pkg::PIXEL_W-1:0] req_second_in,
   input  logic [rycc_pkg::PIXEL_W-1:0] req_third_in,
   input  logic [rycc_pkg::PIXEL_W-1:0] req_alpha_in,
   output logic rsp_valid,
   output logic [rycc_pkg::PIXEL_W-1:0] rsp_first_out,
   output logic [rycc_pkg::PIXEL_W-1:0] rsp_second_out,
   output logic [rycc_pkg::PIXEL_W-1:0] rsp_third_out,
   output logic [rycc_pkg::PIXEL_W-1:0] rsp_alpha_out,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_direction
);
   import rycc_pkg::*;

   localparam int ACC_W = COEF_FRAC_BITS + 15;

   logic busy_ff;
   dir_type direction_ff;
   dir_type direction_in;
   beat_ctl_type opnd_ctl;
   beat_ctl_type acc_ctl;
   logic signed [OPND_W-1:0] opnd [CHANNELS];
   logic signed [ACC_W-1:0] acc [CHANNELS];
   logic [PIXEL_W-1:0] pix [CHANNELS];

   always_comb begin
      direction_in = direction_ff;
      if (csr_valid && csr_ready) begin
         direction_in = dir_type'(csr_direction);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         direction_ff <= DIR_RGB_TO_YCC;
      end else begin
         busy_ff <= 1'b0;
         direction_ff <= direction_in;
      end
   end

   assign busy = busy_ff;
   assign csr_ready = !busy_ff;

   rycc_operand_stage u_operand (
      .clock(clock),
      .reset(reset),
      .take(start && !busy_ff),
      .dir(direction_ff),
      .first_in(req_first_in),
      .second_in(req_second_in),
      .third_in(req_third_in),
      .alpha_in(req_alpha_in),
      .ctl_out(opnd_ctl),
      .opnd_out(opnd)
   );

   rycc_mul_add #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .ACC_W(ACC_W)
   ) u_mul_add (
      .clock(clock),
      .reset(reset),
      .ctl_in(opnd_ctl),
      .opnd_in(opnd),
      .ctl_out(acc_ctl),
      .acc_out(acc)
   );

   rycc_saturate #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .ACC_W(ACC_W)
   ) u_saturate (
      .clock(clock),
      .reset(reset),
      .ctl_in(acc_ctl),
      .acc_in(acc),
      .valid_out(rsp_valid),
      .pix_out(pix),
      .alpha_out(rsp_alpha_out)
   );

   assign rsp_first_out = pix[0];
   assign rsp_second_out = pix[1];
   assign rsp_third_out = pix[2];

   a_beat_in_beat_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted beat did not come out four cycles later");

   a_no_phantom_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result strobe without an accepted beat");

   a_alpha_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alpha_out == $past(req_alpha_in, 4)))
      else $error("alpha does not match its beat");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !busy)
      else $error("busy raised outside reset recovery");

endmodule

// ===== rtl/core/rycc_operand_stage.sv =====
`timescale 1ns / 1ps

module rycc_operand_stage (
   input  logic clock,
   input  logic reset,
   input  logic take,
   input  rycc_pkg::dir_type dir,
   input  logic [rycc_pkg::PIXEL_W-1:0] first_in,
   input  logic [rycc_pkg::PIXEL_W-1:0] second_in,
   input  logic [rycc_pkg::PIXEL_W-1:0] third_in,
   input  logic [rycc_pkg::PIXEL_W-1:0] alpha_in,
   output rycc_pkg::beat_ctl_type ctl_out,
   output logic signed [rycc_pkg::OPND_W-1:0] opnd_out [rycc_pkg::CHANNELS]
);
   import rycc_pkg::*;

   localparam logic signed [OPND_W-1:0] CHROMA_MID = OPND_W'(255);

   beat_ctl_type ctl_ff;
   beat_ctl_type ctl_in;
   logic signed [OPND_W-1:0] opnd_ff [CHANNELS];
   logic signed [OPND_W-1:0] opnd_in [CHANNELS];

   // In the YCbCr to RGB direction the chroma inputs enter doubled and centered.
   always_comb begin
      ctl_in.valid = take;
      ctl_in.dir = dir;
      ctl_in.alpha = alpha_in;
      opnd_in[0] = signed'({2'b00, first_in});
      if (dir == DIR_YCC_TO_RGB) begin
         opnd_in[1] = signed'({1'b0, second_in, 1'b0}) - CHROMA_MID;
         opnd_in[2] = signed'({1'b0, third_in, 1'b0}) - CHROMA_MID;
      end else begin
         opnd_in[1] = signed'({2'b00, second_in});
         opnd_in[2] = signed'({2'b00, third_in});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.dir <= ctl_in.dir;
      ctl_ff.alpha <= ctl_in.alpha;
      opnd_ff <= opnd_in;
   end

   assign ctl_out = ctl_ff;
   assign opnd_out = opnd_ff;

endmodule

// ===== rtl/core/rycc_mul_add.sv =====
`timescale 1ns / 1ps

module rycc_mul_add #(
   parameter int COEF_FRAC_BITS = rycc_pkg::COEF_FRAC_BITS_DEFAULT,
   parameter int ACC_W = COEF_FRAC_BITS + 15
) (
   input  logic clock,
   input  logic reset,
   input  rycc_pkg::beat_ctl_type ctl_in,
   input  logic signed [rycc_pkg::OPND_W-1:0] opnd_in [rycc_pkg::CHANNELS],
   output rycc_pkg::beat_ctl_type ctl_out,
   output logic signed [ACC_W-1:0] acc_out [rycc_pkg::CHANNELS]
);
   import rycc_pkg::*;

   localparam int F = COEF_FRAC_BITS;
   localparam int CW = F + 3;
   localparam int PROD_W = CW + OPND_W;

   localparam longint K_YR = ((longint'(299) << F) + 500) / 1000;
   localparam longint K_YG = ((longint'(587) << F) + 500) / 1000;
   localparam longint K_YB = ((longint'(114) << F) + 500) / 1000;
   localparam longint K_CBR = ((longint'(1687) << F) + 5000) / 10000;
   localparam longint K_CBG = ((longint'(3313) << F) + 5000) / 10000;
   localparam longint K_HALF = ((longint'(1) << F) + 1) / 2;
   localparam longint K_CRG = ((longint'(4187) << F) + 5000) / 10000;
   localparam longint K_CRB = ((longint'(813) << F) + 5000) / 10000;
   localparam longint K_RCR = ((longint'(1402) << F) + 500) / 1000;
   localparam longint K_GCB = ((longint'(34414) << F) + 50000) / 100000;
   localparam longint K_GCR = ((longint'(71414) << F) + 50000) / 100000;
   localparam longint K_BCB = ((longint'(1772) << F) + 500) / 1000;
   localparam longint K_UNIT = longint'(1) << (F + 1);

   localparam logic signed [CW-1:0] COEF_TO_YCC [CHANNELS][CHANNELS] = '{
      '{CW'(2 * K_YR), CW'(2 * K_YG), CW'(2 * K_YB)},
      '{CW'(-2 * K_CBR), CW'(-2 * K_CBG), CW'(2 * K_HALF)},
      '{CW'(2 * K_HALF), CW'(-2 * K_CRG), CW'(-2 * K_CRB)}
   };
   localparam logic signed [CW-1:0] COEF_TO_RGB [CHANNELS][CHANNELS] = '{
      '{CW'(K_UNIT), CW'(0), CW'(K_RCR)},
      '{CW'(K_UNIT), CW'(-K_GCB), CW'(-K_GCR)},
      '{CW'(K_UNIT), CW'(K_BCB), CW'(0)}
   };
   localparam logic signed [ACC_W-1:0] CHROMA_OFFS = ACC_W'(longint'(255) << F);

   beat_ctl_type prod_ctl_ff;
   beat_ctl_type acc_ctl_ff;
   logic signed [PROD_W-1:0] prod_ff [CHANNELS][CHANNELS];
   logic signed [PROD_W-1:0] prod_in [CHANNELS][CHANNELS];
   logic signed [ACC_W-1:0] acc_ff [CHANNELS];
   logic signed [ACC_W-1:0] acc_in [CHANNELS];

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int k = 0; k < CHANNELS; k++) begin
            if (ctl_in.dir == DIR_YCC_TO_RGB) begin
               prod_in[ch][k] = PROD_W'(COEF_TO_RGB[ch][k] * opnd_in[k]);
            end else begin
               prod_in[ch][k] = PROD_W'(COEF_TO_YCC[ch][k] * opnd_in[k]);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         acc_in[ch] = ACC_W'(prod_ff[ch][0]) + ACC_W'(prod_ff[ch][1])
            + ACC_W'(prod_ff[ch][2]);
         if (prod_ctl_ff.dir == DIR_RGB_TO_YCC && ch != 0) begin
            acc_in[ch] = acc_in[ch] + CHROMA_OFFS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff.valid <= 1'b0;
         acc_ctl_ff.valid <= 1'b0;
      end else begin
         prod_ctl_ff.valid <= ctl_in.valid;
         acc_ctl_ff.valid <= prod_ctl_ff.valid;
      end
      prod_ctl_ff.dir <= ctl_in.dir;
      prod_ctl_ff.alpha <= ctl_in.alpha;
      acc_ctl_ff.dir <= prod_ctl_ff.dir;
      acc_ctl_ff.alpha <= prod_ctl_ff.alpha;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   assign ctl_out = acc_ctl_ff;
   assign acc_out = acc_ff;

endmodule

// ===== rtl/core/rycc_saturate.sv =====
`timescale 1ns / 1ps

module rycc_saturate #(
   parameter int COEF_FRAC_BITS = rycc_pkg::COEF_FRAC_BITS_DEFAULT,
   parameter int ACC_W = COEF_FRAC_BITS + 15
) (
   input  logic clock,
   input  logic reset,
   input  rycc_pkg::beat_ctl_type ctl_in,
   input  logic signed [ACC_W-1:0] acc_in [rycc_pkg::CHANNELS],
   output logic valid_out,
   output logic [rycc_pkg::PIXEL_W-1:0] pix_out [rycc_pkg::CHANNELS],
   output logic [rycc_pkg::PIXEL_W-1:0] alpha_out
);
   import rycc_pkg::*;

   localparam int SHIFT = COEF_FRAC_BITS + 1;
   localparam logic signed [ACC_W-1:0] TOP = ACC_W'(longint'(255) << SHIFT);

   logic valid_ff;
   logic [PIXEL_W-1:0] alpha_ff;
   logic [PIXEL_W-1:0] pix_ff [CHANNELS];
   logic [PIXEL_W-1:0] pix_in [CHANNELS];

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (acc_in[ch][ACC_W-1]) begin
            pix_in[ch] = '0;
         end else if (acc_in[ch] > TOP) begin
            pix_in[ch] = '1;
         end else begin
            pix_in[ch] = acc_in[ch][SHIFT +: PIXEL_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_in.valid;
      end
      alpha_ff <= ctl_in.alpha;
      pix_ff <= pix_in;
   end

   assign valid_out = valid_ff;
   assign pix_out = pix_ff;
   assign alpha_out = alpha_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import rycc_pkg::*;

   localparam int FRAC = COEF_FRAC_BITS_DEFAULT;
   localparam int RANDOM_PHASES = 6;
   localparam int PIXELS_PER_PHASE = 117;

   typedef struct packed {
      logic [PIXEL_W-1:0] first;
      logic [PIXEL_W-1:0] second;
      logic [PIXEL_W-1:0] third;
      logic [PIXEL_W-1:0] alpha;
   } pixel_type;

   typedef struct {
      dir_type dir;
      pixel_type pixel;
      bit known;
      pixel_type result;
   } pixel_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [PIXEL_W-1:0] req_first_in = '0;
   logic [PIXEL_W-1:0] req_second_in = '0;
   logic [PIXEL_W-1:0] req_third_in = '0;
   logic [PIXEL_W-1:0] req_alpha_in = '0;
   logic rsp_valid;
   logic [PIXEL_W-1:0] rsp_first_out;
   logic [PIXEL_W-1:0] rsp_second_out;
   logic [PIXEL_W-1:0] rsp_third_out;
   logic [PIXEL_W-1:0] rsp_alpha_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_direction = 1'b0;

   logic typed_valid = 1'b0;
   pixel_type typed_pixel = '0;

   dir_type ycc_direction = DIR_RGB_TO_YCC;
   dir_type drive_direction = DIR_RGB_TO_YCC;
   pixel_type pixels_expected[$];
   pixel_case_type pixel_cases[$];
   pixel_type want_pixel;
   int mismatch_count = 0;
   int pixels_checked = 0;
   int directed_count = 0;
   int random_count = 0;
   int direction_writes = 0;

   rgb_ycbcr_color_converter_unit #(
      .COEF_FRAC_BITS(FRAC)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_first_in(req_first_in),
      .req_second_in(req_second_in),
      .req_third_in(req_third_in),
      .req_alpha_in(req_alpha_in),
      .rsp_valid(rsp_valid),
      .rsp_first_out(rsp_first_out),
      .rsp_second_out(rsp_second_out),
      .rsp_third_out(rsp_third_out),
      .rsp_alpha_out(rsp_alpha_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_direction(csr_direction)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #200000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic longint fixed_coef(longint num, longint den);
      return ((num <<< FRAC) + den / 2) / den;
   endfunction

   function automatic logic [PIXEL_W-1:0] clamp_channel(longint acc);
      longint top;
      top = longint'(255) <<< (FRAC + 1);
      if (acc < 0) acc = 0;
      if (acc > top) acc = top;
      return PIXEL_W'(acc >>> (FRAC + 1));
   endfunction

   function automatic pixel_type convert_pixel(dir_type dir, pixel_type pix);
      longint a, b, c, offs, y2, cb, cr;
      longint acc0, acc1, acc2;
      pixel_type res;
      a = pix.first;
      b = pix.second;
      c = pix.third;
      offs = longint'(255) <<< FRAC;
      if (dir == DIR_RGB_TO_YCC) begin
         acc0 = 2 * (fixed_coef(299, 1000) * a + fixed_coef(587, 1000) * b
                + fixed_coef(114, 1000) * c);
         acc1 = 2 * (-fixed_coef(1687, 10000) * a - fixed_coef(3313, 10000) * b
                + fixed_coef(1, 2) * c) + offs;
         acc2 = 2 * (fixed_coef(1, 2) * a - fixed_coef(4187, 10000) * b
                - fixed_coef(813, 10000) * c) + offs;
      end else begin
         y2 = a <<< (FRAC + 1);
         cb = 2 * b - 255;
         cr = 2 * c - 255;
         acc0 = y2 + fixed_coef(1402, 1000) * cr;
         acc1 = y2 - fixed_coef(34414, 100000) * cb - fixed_coef(71414, 100000) * cr;
         acc2 = y2 + fixed_coef(1772, 1000) * cb;
      end
      res.first = clamp_channel(acc0);
      res.second = clamp_channel(acc1);
      res.third = clamp_channel(acc2);
      res.alpha = pix.alpha;
      return res;
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_level();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2, 3: return PIXEL_W'($urandom_range(120, 135));
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ycc_direction = DIR_RGB_TO_YCC;
      end else begin
         if (rsp_valid) begin
            if (pixels_expected.size() == 0) begin
               $error("result beat with no pixel outstanding");
               mismatch_count++;
            end else begin
               want_pixel = pixels_expected.pop_front();
               pixels_checked++;
               if (rsp_first_out !== want_pixel.first) begin
                  $error("first_out: expected %0d, got %0d", want_pixel.first, rsp_first_out);
                  mismatch_count++;
               end
               if (rsp_second_out !== want_pixel.second) begin
                  $error("second_out: expected %0d, got %0d", want_pixel.second,
                         rsp_second_out);
                  mismatch_count++;
               end
               if (rsp_third_out !== want_pixel.third) begin
                  $error("third_out: expected %0d, got %0d", want_pixel.third, rsp_third_out);
                  mismatch_count++;
               end
               if (rsp_alpha_out !== want_pixel.alpha) begin
                  $error("alpha_out: expected %0d, got %0d", want_pixel.alpha, rsp_alpha_out);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            ycc_direction = dir_type'(csr_direction);
         end
         if (start && !busy) begin
            if (typed_valid) begin
               pixels_expected.push_back(typed_pixel);
            end else begin
               pixels_expected.push_back(convert_pixel(ycc_direction,
                  {req_first_in, req_second_in, req_third_in, req_alpha_in}));
            end
         end
      end
   end

   task automatic drive_pixel(pixel_type pix, bit known, pixel_type result);
      start <= 1'b1;
      req_first_in <= pix.first;
      req_second_in <= pix.second;
      req_third_in <= pix.third;
      req_alpha_in <= pix.alpha;
      typed_valid <= known;
      typed_pixel <= result;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(int odds);
      if (odds > 0 && $urandom_range(1, odds) == 1) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pixels_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_direction(dir_type dir);
      wait_drained();
      idle_gap(2);
      csr_valid <= 1'b1;
      csr_direction <= dir;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      drive_direction = dir;
      direction_writes++;
   endtask

   task automatic add_case(dir_type dir, int f, int s, int t, int a, bit known,
                           int ef = 0, int es = 0, int et = 0);
      pixel_case_type pc;
      pc.dir = dir;
      pc.pixel = {8'(f), 8'(s), 8'(t), 8'(a)};
      pc.known = known;
      pc.result = {8'(ef), 8'(es), 8'(et), 8'(a)};
      pixel_cases.push_back(pc);
   endtask

   initial begin
      pixel_type pix;
      int phase_odds;
      bit quiet;

      add_case(DIR_RGB_TO_YCC, 0, 0, 0, 0, 1, 0, 127, 127);
      add_case(DIR_RGB_TO_YCC, 255, 255, 255, 255, 1, 255, 127, 127);
      add_case(DIR_RGB_TO_YCC, 128, 128, 128, 90, 1, 128, 127, 127);
      add_case(DIR_RGB_TO_YCC, 255, 0, 0, 165, 0);
      add_case(DIR_RGB_TO_YCC, 0, 255, 0, 1, 0);
      add_case(DIR_RGB_TO_YCC, 0, 0, 255, 128, 0);
      add_case(DIR_RGB_TO_YCC, 0, 255, 255, 127, 0);
      add_case(DIR_RGB_TO_YCC, 255, 255, 0, 254, 0);
      add_case(DIR_RGB_TO_YCC, 255, 0, 255, 85, 0);
      add_case(DIR_RGB_TO_YCC, 1, 2, 3, 170, 0);
      add_case(DIR_YCC_TO_RGB, 0, 0, 0, 0, 0);
      add_case(DIR_YCC_TO_RGB, 255, 255, 255, 255, 0);
      add_case(DIR_YCC_TO_RGB, 128, 128, 128, 15, 0);
      add_case(DIR_YCC_TO_RGB, 0, 128, 128, 240, 0);
      add_case(DIR_YCC_TO_RGB, 255, 127, 127, 51, 0);
      add_case(DIR_YCC_TO_RGB, 0, 0, 255, 204, 0);
      add_case(DIR_YCC_TO_RGB, 0, 255, 0, 102, 0);
      add_case(DIR_YCC_TO_RGB, 255, 0, 0, 153, 0);
      add_case(DIR_YCC_TO_RGB, 255, 0, 255, 17, 0);
      add_case(DIR_YCC_TO_RGB, 0, 255, 255, 34, 0);
      add_case(DIR_YCC_TO_RGB, 76, 85, 255, 68, 0);
      add_case(DIR_YCC_TO_RGB, 29, 255, 107, 136, 0);
      add_case(DIR_RGB_TO_YCC, 200, 100, 50, 221, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_direction(DIR_RGB_TO_YCC);

      foreach (pixel_cases[i]) begin
         if (pixel_cases[i].dir != drive_direction) set_direction(pixel_cases[i].dir);
         drive_pixel(pixel_cases[i].pixel, pixel_cases[i].known, pixel_cases[i].result);
         directed_count++;
         idle_gap(4);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         quiet = (phase == 2) || (phase == RANDOM_PHASES - 1);
         phase_odds = quiet ? 0 : $urandom_range(3, 8);
         set_direction(phase % 2 == 0 ? DIR_YCC_TO_RGB : DIR_RGB_TO_YCC);
         for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
            pix.first = pick_level();
            pix.second = pick_level();
            pix.third = pick_level();
            pix.alpha = PIXEL_W'($urandom_range(0, 255));
            if ($urandom_range(0, 15) == 0) pix.second = pix.first;
            if ($urandom_range(0, 15) == 0) pix.third = pix.second;
            drive_pixel(pix, 1'b0, '0);
            random_count++;
            idle_gap(phase_odds);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (pixels_expected.size() != 0) begin
         $error("%0d pixels never came back", pixels_expected.size());
         mismatch_count++;
      end
      $display("Converted %0d directed and %0d random pixels in both directions, %0d beats",
               directed_count, random_count, pixels_checked);
      $display("checked, %0d direction writes, %0d mismatches.", direction_writes,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
